// File: design/kcp_pkg.sv
// ----------------------------------------------------------------------------
// kcp_pkg
// Shared types, codes and the seed table of the keyed code pair cipher.
// ----------------------------------------------------------------------------
package kcp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEED_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] KEY_MARKER = 32'hDEADFACE;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KEY = 1'b1;

  // transform kinds selected by a key byte
  localparam logic [BYTE_W-1:0] XT_XOR     = 8'd0;
  localparam logic [BYTE_W-1:0] XT_SWAP    = 8'd1;
  localparam logic [BYTE_W-1:0] XT_ADD     = 8'd2;
  localparam logic [BYTE_W-1:0] XT_SUB     = 8'd3;
  localparam logic [BYTE_W-1:0] XT_XOR_ADD = 8'd4;
  localparam logic [BYTE_W-1:0] XT_MIX     = 8'd5;
  localparam logic [BYTE_W-1:0] XT_ROLL    = 8'd6;
  localparam logic [BYTE_W-1:0] XT_INVERT  = 8'd7;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    byte_t kind;
    byte_t seed;
  } kcp_half_key_t;

  localparam byte_t SEED_ROM [4][32] = '{
    '{8'h00, 8'h1F, 8'h9B, 8'h69, 8'hA5, 8'h80, 8'h90, 8'hB2,
      8'hD7, 8'h44, 8'hEC, 8'h75, 8'h3B, 8'h62, 8'h0C, 8'hA3,
      8'hA6, 8'hE4, 8'h1F, 8'h4C, 8'h05, 8'hE4, 8'h44, 8'h6E,
      8'hD9, 8'h5B, 8'h34, 8'hE6, 8'h08, 8'h31, 8'h91, 8'h72},
    '{8'h00, 8'hAE, 8'hF3, 8'h7B, 8'h12, 8'hC9, 8'h83, 8'hF0,
      8'hA9, 8'h57, 8'h50, 8'h08, 8'h04, 8'h81, 8'h02, 8'h21,
      8'h96, 8'h09, 8'h0F, 8'h90, 8'hC3, 8'h62, 8'h27, 8'h21,
      8'h3B, 8'h22, 8'h4E, 8'h88, 8'hF5, 8'hC5, 8'h75, 8'h91},
    '{8'h00, 8'hE3, 8'hA2, 8'h45, 8'h40, 8'hE0, 8'h09, 8'hEA,
      8'h42, 8'h65, 8'h1C, 8'hC1, 8'hEB, 8'hB0, 8'h69, 8'h14,
      8'h01, 8'hD2, 8'h8E, 8'hFB, 8'hFA, 8'h86, 8'h09, 8'h95,
      8'h1B, 8'h61, 8'h14, 8'h0E, 8'h99, 8'h21, 8'hEC, 8'h40},
    '{8'h00, 8'h25, 8'h6D, 8'h4F, 8'hC5, 8'hCA, 8'h04, 8'h39,
      8'h3A, 8'h7D, 8'h0D, 8'hF1, 8'h43, 8'h05, 8'h71, 8'h66,
      8'h82, 8'h31, 8'h21, 8'hD8, 8'hFE, 8'h4D, 8'hC2, 8'hC8,
      8'hCC, 8'h09, 8'hA0, 8'h06, 8'h49, 8'hD5, 8'hF1, 8'h83}
  };

  function automatic byte_t swap_nibbles(input byte_t b);
    return {b[3:0], b[7:4]};
  endfunction

endpackage

// File: design/kcp_word_xform.sv
// ----------------------------------------------------------------------------
// kcp_word_xform
// Byte-wise table transform of one 32-bit word under one half of the key.
// ----------------------------------------------------------------------------
module kcp_word_xform import kcp_pkg::*; (
  input  word_t         word_in,
  input  kcp_half_key_t hkey,
  input  logic          enc,
  output word_t         word_out
);

  logic [SEED_W-1:0] s;
  byte_t r0, r1, r2, r3;
  byte_t r1p, r2p, r3p;
  byte_t b0, b1, b2, b3;
  word_t swap_word;
  word_t xf_word;

  assign s   = hkey.seed[SEED_W-1:0];
  assign r0  = SEED_ROM[0][s];
  assign r1  = SEED_ROM[1][s];
  assign r2  = SEED_ROM[2][s];
  assign r3  = SEED_ROM[3][s];
  assign r1p = SEED_ROM[1][s + SEED_W'(1)];
  assign r2p = SEED_ROM[2][s + SEED_W'(2)];
  assign r3p = SEED_ROM[3][s + SEED_W'(3)];

  assign b0 = word_in[7:0];
  assign b1 = word_in[15:8];
  assign b2 = word_in[23:16];
  assign b3 = word_in[31:24];

  // nibble swap path, shared with odd-seed invert kind
  always_comb begin
    if (enc) begin
      swap_word = {swap_nibbles(b3 ^ r0), swap_nibbles(b2 ^ r2),
                   swap_nibbles(b1 ^ r3), swap_nibbles(b0 ^ r1)};
    end else begin
      swap_word = {swap_nibbles(b3) ^ r0, swap_nibbles(b2) ^ r2,
                   swap_nibbles(b1) ^ r3, swap_nibbles(b0) ^ r1};
    end
  end

  always_comb begin
    case (hkey.kind)
      XT_XOR: begin
        xf_word = {b3 ^ r0, b2 ^ r1, b1 ^ r2, b0 ^ r3};
      end
      XT_SWAP: begin
        xf_word = swap_word;
      end
      XT_ADD: begin
        if (enc) begin
          xf_word = {b3 - r0, b2 - r1, b1 - r2, b0 - r3};
        end else begin
          xf_word = {b3 + r0, b2 + r1, b1 + r2, b0 + r3};
        end
      end
      XT_SUB: begin
        if (enc) begin
          xf_word = {b3 + r3, b2 + r2, b1 + r1, b0 + r0};
        end else begin
          xf_word = {b3 - r3, b2 - r2, b1 - r1, b0 - r0};
        end
      end
      XT_XOR_ADD: begin
        if (enc) begin
          xf_word = {byte_t'(b3 - r0) ^ r0, byte_t'(b2 - r3) ^ r3,
                     byte_t'(b1 - r1) ^ r1, byte_t'(b0 - r2) ^ r2};
        end else begin
          xf_word = {byte_t'((b3 ^ r0) + r0), byte_t'((b2 ^ r3) + r3),
                     byte_t'((b1 ^ r1) + r1), byte_t'((b0 ^ r2) + r2)};
        end
      end
      XT_MIX: begin
        if (enc) begin
          xf_word = {byte_t'((b3 ^ r0) + r1), byte_t'((b2 ^ r1) + r2),
                     byte_t'((b1 ^ r2) + r3), byte_t'((b0 ^ r3) + r0)};
        end else begin
          xf_word = {byte_t'(b3 - r1) ^ r0, byte_t'(b2 - r2) ^ r1,
                     byte_t'(b1 - r3) ^ r2, byte_t'(b0 - r0) ^ r3};
        end
      end
      XT_ROLL: begin
        if (enc) begin
          xf_word = {b3 - r0, b2 + r1p, b1 - r2p, b0 + r3p};
        end else begin
          xf_word = {b3 + r0, b2 - r1p, b1 + r2p, b0 - r3p};
        end
      end
      XT_INVERT: begin
        xf_word = hkey.seed[0] ? swap_word : ~word_in;
      end
      default: begin
        xf_word = word_in;
      end
    endcase
  end

  assign word_out = xf_word;

endmodule

// File: design/keyed_code_pair_cipher_core.sv
// ----------------------------------------------------------------------------
// keyed_code_pair_cipher_core
// A pair goes from input request accept to out_valid through the input
// register, then the result register. Throughput: one pair per cycle while
// out_stall does not hold the output, set by the single running key register
// that is updated in the same cycle a pair is transformed. Reset: synchronous
// active-low rst_n clears both valid flags, direction and the running key to 0.
// ----------------------------------------------------------------------------
module keyed_code_pair_cipher_core import kcp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  word_t                in_address_word,
  input  word_t                in_value_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output word_t                out_result_address,
  output word_t                out_result_value
);

  logic  s1_valid_r, s1_valid_nxt;
  word_t s1_addr_r, s1_val_r;
  logic  out_valid_r, out_valid_nxt;
  word_t out_addr_r, out_val_r;
  logic  direction_r, direction_nxt;
  word_t key_r, key_nxt;

  logic  out_free, s1_move, in_take, drop_pair;
  word_t ra, rv;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  kcp_word_xform u_addr_xform (
    .word_in  (s1_addr_r),
    .hkey     ('{kind: key_r[31:24], seed: key_r[23:16]}),
    .enc      (direction_r),
    .word_out (ra)
  );

  kcp_word_xform u_val_xform (
    .word_in  (s1_val_r),
    .hkey     ('{kind: key_r[15:8], seed: key_r[7:0]}),
    .enc      (direction_r),
    .word_out (rv)
  );

  // decrypted marker pair loads the key and is dropped
  assign drop_pair = !direction_r && (ra == KEY_MARKER);

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);

    if (s1_move) begin
      out_valid_nxt = !drop_pair;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end

    direction_nxt = direction_r;
    key_nxt       = key_r;
    if (s1_move) begin
      if (direction_r) begin
        if (s1_addr_r == KEY_MARKER) begin
          key_nxt = s1_val_r;
        end
      end else if (drop_pair) begin
        key_nxt = rv;
      end
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DIRECTION: begin
          direction_nxt = cfg_wdata[0];
        end
        CFG_INITIAL_KEY: begin
          key_nxt = cfg_wdata;
        end
        default: begin
          direction_nxt = direction_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      direction_r <= 1'b0;
      key_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      direction_r <= direction_nxt;
      key_r       <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_addr_r <= in_address_word;
      s1_val_r  <= in_value_word;
    end
    if (s1_move) begin
      out_addr_r <= ra;
      out_val_r  <= rv;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_result_value   = out_val_r;

endmodule
